// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the burst detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound burst detector package
// Widths, codes, register defaults and shared types of the detector.
// ----------------------------------------------------------------------------
package sbd_pkg;

   // Payload and counter widths
   localparam int COUNT_WIDTH        = 16;
   localparam int BURST_NUMBER_WIDTH = 16;
   localparam int HOLDOFF_WIDTH      = 16;
   localparam int CSR_DATA_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH    = 2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE         = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDOFF_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOUND_POLARITY = 2'd2;

   // Register reset values
   localparam logic                     ENABLE_RESET         = 1'b1;
   localparam logic [HOLDOFF_WIDTH-1:0] HOLDOFF_TICKS_RESET  = 16'd200;
   localparam logic                     SOUND_POLARITY_RESET = 1'b0;

   // Event kinds
   localparam logic EVENT_BEGIN = 1'b0;
   localparam logic EVENT_END   = 1'b1;

   // Detector modes
   typedef enum logic [2:0] {
      MODE_QUIET = 3'b001,
      MODE_NOISY = 3'b010,
      MODE_HOLD  = 3'b100
   } mode_type;

   // Configuration as seen by the detector core
   typedef struct packed {
      logic                     enable;
      logic [HOLDOFF_WIDTH-1:0] holdoff_ticks;
      logic                     sound_polarity;
   } cfg_type;

   // Core state exported for checking
   typedef struct packed {
      mode_type               mode;
      logic [COUNT_WIDTH-1:0] burst_total;
   } status_type;

endpackage

// ===== rtl/core/sbd_req_if.sv =====
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel that carries one sampled sensor level per item.
// ----------------------------------------------------------------------------
interface sbd_req_if;
   logic valid;
   logic ready;
   logic sample_level;

   modport source (output valid, output sample_level, input ready);
   modport sink   (input valid, input sample_level, output ready);
endinterface

// ===== rtl/core/sbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries burst begin and end events.
// ----------------------------------------------------------------------------
interface sbd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   event_kind;
   logic [sbd_pkg::BURST_NUMBER_WIDTH-1:0] burst_number;

   modport source (output valid, output event_kind, output burst_number, input ready);
   modport sink   (input valid, input event_kind, input burst_number, output ready);
endinterface

// ===== rtl/core/sbd_csr.sv =====
// ----------------------------------------------------------------------------
// Burst detector configuration registers
// Holds enable, hold-off length and polarity; flags a re-enable write.
// ----------------------------------------------------------------------------
module sbd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [sbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sbd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output sbd_pkg::cfg_type                    cfg,
   output logic                                resume
);
   import sbd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    resume_in;

   // Decode one register write
   always_comb begin
      cfg_in    = cfg_ff;
      resume_in = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE: begin
               cfg_in.enable = csr_write_data[0];
               resume_in     = csr_write_data[0] & ~cfg_ff.enable;
            end
            CSR_HOLDOFF_TICKS: begin
               cfg_in.holdoff_ticks = csr_write_data[HOLDOFF_WIDTH-1:0];
            end
            CSR_SOUND_POLARITY: begin
               cfg_in.sound_polarity = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= ENABLE_RESET;
         cfg_ff.holdoff_ticks  <= HOLDOFF_TICKS_RESET;
         cfg_ff.sound_polarity <= SOUND_POLARITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Restart in quiet at the same edge that sets enable
   assign cfg    = cfg_ff;
   assign resume = resume_in;

endmodule

// ===== rtl/core/sbd_core.sv =====
// ----------------------------------------------------------------------------
// Burst detector core
// Edge detection, mode update, hold-off timer and the event output register.
// ----------------------------------------------------------------------------
module sbd_core (
   input  logic                clock,
   input  logic                reset,
   input  sbd_pkg::cfg_type    cfg,
   input  logic                resume,
   input  logic                item_valid,
   input  logic                item_level,
   output logic                advance,
   output sbd_pkg::status_type status,
   sbd_rsp_if.source           rsp
);
   import sbd_pkg::*;

   logic                          prior_ff;
   logic                          prior_in;
   mode_type                      mode_ff;
   mode_type                      mode_in;
   logic [HOLDOFF_WIDTH-1:0]      elapsed_ff;
   logic [HOLDOFF_WIDTH-1:0]      elapsed_in;
   logic [COUNT_WIDTH-1:0]        total_ff;
   logic [COUNT_WIDTH-1:0]        total_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic                          out_kind_ff;
   logic [BURST_NUMBER_WIDTH-1:0] out_number_ff;
   logic                          sound;
   logic                          edge_done;
   logic                          emit;
   logic                          emit_kind;

   // Advance when the output register is free or being drained
   assign advance = item_valid & (~out_valid_ff | rsp.ready);
   assign sound   = (item_level == cfg.sound_polarity);

   // Update the detector for one tick
   always_comb begin
      prior_in   = prior_ff;
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      total_in   = total_ff;
      edge_done  = 1'b0;
      emit       = 1'b0;
      emit_kind  = EVENT_BEGIN;
      if (advance && cfg.enable) begin
         // Handle a change of the sound flag
         if (sound != prior_ff) begin
            prior_in = sound;
            if (sound) begin
               case (mode_ff)
                  MODE_QUIET: begin
                     mode_in   = MODE_NOISY;
                     total_in  = total_ff + COUNT_WIDTH'(1);
                     emit      = 1'b1;
                     emit_kind = EVENT_BEGIN;
                     edge_done = 1'b1;
                  end
                  MODE_HOLD: begin
                     mode_in   = MODE_NOISY;
                     edge_done = 1'b1;
                  end
                  default: begin
                     edge_done = 1'b0;
                  end
               endcase
            end else if (mode_ff == MODE_NOISY) begin
               mode_in    = MODE_HOLD;
               elapsed_in = '0;
               edge_done  = 1'b1;
            end
         end
         // Run the hold-off timer
         if (!edge_done && mode_ff == MODE_HOLD) begin
            if (elapsed_ff >= cfg.holdoff_ticks) begin
               mode_in   = MODE_QUIET;
               emit      = 1'b1;
               emit_kind = EVENT_END;
            end else begin
               elapsed_in = elapsed_ff + HOLDOFF_WIDTH'(1);
            end
         end
      end
      // Re-enable restarts in quiet
      if (resume) begin
         mode_in = MODE_QUIET;
      end
   end

   assign out_valid_in = advance ? emit : (out_valid_ff & ~rsp.ready);

   // Hold the detector state and the output control
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff     <= 1'b0;
         mode_ff      <= MODE_QUIET;
         elapsed_ff   <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prior_ff     <= prior_in;
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the event payload
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_kind_ff   <= emit_kind;
         out_number_ff <= BURST_NUMBER_WIDTH'(total_in);
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.event_kind   = out_kind_ff;
   assign rsp.burst_number = out_number_ff;

   assign status.mode        = mode_ff;
   assign status.burst_total = total_ff;

endmodule

// ===== rtl/core/sound_burst_detector_unit.sv =====
// Path: an accepted item is held in the input register; its event is then loaded
// into the event output register, from which rsp_ch can take it.
// Throughput: one tick item per cycle; the input register and the event
// output register stall together only while an event waits on rsp_ch.
// A tick that causes no event leaves the input register without loading the event output register.
// Reset: synchronous, active high; registers return to their defaults and
// ----------------------------------------------------------------------------
// Sound burst detector unit
// Top level: tick input register, configuration registers and detector core.
// The detector returns to quiet with a zero burst count at reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sound_burst_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   sbd_req_if.sink                             req_ch,
   sbd_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [sbd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sbd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import sbd_pkg::*;

   cfg_type    cfg;
   status_type status;
   logic       resume;
   logic       advance;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_level_ff;
   logic       req_take;

   // Take a new item when the input register is empty or moving on
   assign req_ch.ready = ~in_valid_ff | advance;
   assign req_take     = req_ch.valid & req_ch.ready;
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);

   // Hold the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_ch.sample_level;
      end
   end

   sbd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .resume           (resume)
   );

   sbd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .resume     (resume),
      .item_valid (in_valid_ff),
      .item_level (in_level_ff),
      .advance    (advance),
      .status     (status),
      .rsp        (rsp_ch)
   );

   // A waiting event with a full input register blocks new items
   `ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, rsp_ch.valid && !rsp_ch.ready && in_valid_ff, !req_ch.ready)
   // An accepted item lands in the input register
   `ASSERT_NEXT(a_take_fills_input, clock, reset, req_ch.valid && req_ch.ready, in_valid_ff)
   // A shown event carries the current burst count
   `ASSERT_IMPLIES(a_event_matches_count, clock, reset, rsp_ch.valid, rsp_ch.burst_number == BURST_NUMBER_WIDTH'(status.burst_total))

endmodule
